[design/ped_pkg.sv]
// ----------------------------------------------------------------------------
// ped_pkg - shared types and constants for the percent escape decoder
// Holds the escape phase codes, the bundle that travels from the front end
// to the back end, and the hex digit classifier.
// ----------------------------------------------------------------------------
package ped_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned MAX_OUT  = 3;
	localparam int unsigned CNT_W    = 2;
	localparam int unsigned QDEPTH   = 4;
	localparam int unsigned QPTR_W   = 2;
	localparam int unsigned NIBBLE_W = 4;

	localparam logic [BYTE_W-1:0] PCT_CHAR = 8'h25;

	// escape phase, one-hot
	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_PCT   = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	// up to three output bytes caused by one input transaction
	typedef struct packed {
		logic [CNT_W-1:0]                  cnt;
		logic [MAX_OUT-1:0][BYTE_W-1:0]    bytes;
		logic                              last;
	} bundle_t;

	typedef struct packed {
		logic                ok;
		logic [NIBBLE_W-1:0] val;
	} hex_t;

	// classify a character as a hex digit, either case
	function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
		hex_t h;
		h.ok  = 1'b0;
		h.val = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.ok  = 1'b1;
			h.val = NIBBLE_W'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.ok  = 1'b1;
			h.val = NIBBLE_W'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.ok  = 1'b1;
			h.val = NIBBLE_W'(c - 8'h57);
		end
		return h;
	endfunction

endpackage

[design/ped_front.sv]
// ----------------------------------------------------------------------------
// ped_front - escape classifier
// Takes one raw byte a cycle when take is high, tracks the escape phase and
// held digit, and turns each transaction into a bundle of zero to three bytes.
// ----------------------------------------------------------------------------
module ped_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [ped_pkg::BYTE_W-1:0]  in_byte,
	input  logic                        in_last,
	output logic                        bnd_valid,
	output ped_pkg::bundle_t            bnd
);

	ped_pkg::phase_t                phase_q, nxt_phase;
	logic [ped_pkg::BYTE_W-1:0]     held_q, nxt_held;
	ped_pkg::hex_t                  hc, hh;
	logic [ped_pkg::CNT_W-1:0]      n;

	// decode one byte against the current phase, then flush on end of string
	always_comb begin
		bnd       = '0;
		n         = '0;
		nxt_phase = phase_q;
		nxt_held  = held_q;
		hc        = ped_pkg::hex_decode(in_byte);
		hh        = ped_pkg::hex_decode(held_q);
		unique case (phase_q)
			ped_pkg::PH_PCT: begin
				if (hc.ok) begin
					nxt_held  = in_byte;
					nxt_phase = ped_pkg::PH_DIGIT;
				end else begin
					bnd.bytes[0] = ped_pkg::PCT_CHAR;
					n            = 2'd1;
					if (in_byte == ped_pkg::PCT_CHAR) begin
						nxt_phase = ped_pkg::PH_PCT;
					end else begin
						bnd.bytes[1] = in_byte;
						n            = 2'd2;
						nxt_phase    = ped_pkg::PH_IDLE;
					end
				end
			end
			ped_pkg::PH_DIGIT: begin
				if (hc.ok) begin
					bnd.bytes[0] = {hh.val, hc.val};
					n            = 2'd1;
					nxt_phase    = ped_pkg::PH_IDLE;
				end else begin
					bnd.bytes[0] = ped_pkg::PCT_CHAR;
					bnd.bytes[1] = held_q;
					n            = 2'd2;
					if (in_byte == ped_pkg::PCT_CHAR) begin
						nxt_phase = ped_pkg::PH_PCT;
					end else begin
						bnd.bytes[2] = in_byte;
						n            = 2'd3;
						nxt_phase    = ped_pkg::PH_IDLE;
					end
				end
			end
			default: begin
				if (in_byte == ped_pkg::PCT_CHAR) begin
					nxt_phase = ped_pkg::PH_PCT;
				end else begin
					bnd.bytes[0] = in_byte;
					n            = 2'd1;
					nxt_phase    = ped_pkg::PH_IDLE;
				end
			end
		endcase
		// end of string: emit whatever is still held
		if (in_last) begin
			if (nxt_phase == ped_pkg::PH_PCT) begin
				for (int i = 0; i < ped_pkg::MAX_OUT; i++) begin
					if (n == ped_pkg::CNT_W'(i)) begin
						bnd.bytes[i] = ped_pkg::PCT_CHAR;
					end
				end
				n = n + 2'd1;
			end else if (nxt_phase == ped_pkg::PH_DIGIT) begin
				// only reached from a held '%' with nothing emitted yet
				bnd.bytes[0] = ped_pkg::PCT_CHAR;
				bnd.bytes[1] = nxt_held;
				n            = 2'd2;
			end
			nxt_phase = ped_pkg::PH_IDLE;
		end
		bnd.cnt   = n;
		bnd.last  = in_last;
		bnd_valid = take && (n != '0);
	end

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ped_pkg::PH_IDLE;
		end else if (take) begin
			phase_q <= nxt_phase;
		end
	end

	// held digit, payload only
	always_ff @(posedge clk) begin
		if (take) begin
			held_q <= nxt_held;
		end
	end

endmodule

[design/ped_queue.sv]
// ----------------------------------------------------------------------------
// ped_queue - bundle queue
// Short first-in first-out store of bundles between front and back end.
// The head entry is visible combinationally while the queue is not empty.
// ----------------------------------------------------------------------------
module ped_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  ped_pkg::bundle_t    wr_data,
	input  logic                rd_en,
	output ped_pkg::bundle_t    rd_data,
	output logic                full,
	output logic                empty
);

	ped_pkg::bundle_t           mem_q [ped_pkg::QDEPTH];
	logic [ped_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [ped_pkg::QPTR_W:0]   cnt_q;
	logic                       do_wr, do_rd;

	assign full    = (cnt_q == (ped_pkg::QPTR_W+1)'(ped_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[design/ped_back.sv]
// ----------------------------------------------------------------------------
// ped_back - byte serialiser
// Walks through the bytes of the head bundle, one per output transaction,
// marks the end of the run and of the string, and retires the bundle.
// ----------------------------------------------------------------------------
module ped_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ped_pkg::bundle_t            head,
	input  logic                        head_empty,
	output logic                        head_pop,
	input  logic                        pop,
	output logic                        empty,
	output logic [ped_pkg::BYTE_W-1:0]  out_byte,
	output logic                        run_end,
	output logic                        stream_end
);

	logic [ped_pkg::CNT_W-1:0] idx_q;
	logic                      take;

	// select the current byte of the head bundle
	always_comb begin
		out_byte = head.bytes[0];
		for (int i = 1; i < ped_pkg::MAX_OUT; i++) begin
			if (idx_q == ped_pkg::CNT_W'(i)) begin
				out_byte = head.bytes[i];
			end
		end
	end

	assign empty      = head_empty;
	assign run_end    = (idx_q == head.cnt - 1'b1);
	assign stream_end = run_end && head.last;
	assign take       = pop && !head_empty;
	assign head_pop   = take && run_end;

	// byte index within the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			if (run_end) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

[design/percent_escape_decoder_core.sv]
// ----------------------------------------------------------------------------
// percent_escape_decoder_core - URL percent decoder
// Decodes '%' hex hex escapes in a byte stream with a last-byte mark.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive in_byte/in_last and raise push; a
//   transaction completes on a clock edge with push high and full low.
//   Output side is a queue: while empty is low the oldest decoded byte sits
//   on out_byte with run_end and stream_end; pop takes it.
//   Each input yields zero to three output bytes. A byte that is only held
//   (a '%' or a first hex digit) yields nothing; the string's last byte
//   always yields at least one, the final one carrying stream_end.
//   A byte accepted at an edge is written into the bundle queue at that
//   edge; the queue head drives the outputs combinationally. The input
//   takes one byte per cycle while the four-entry bundle queue has room;
//   the output gives one byte per cycle while pop is high; a three-byte
//   bundle takes three pops. When the receiver stalls, the queue fills and
//   full rises after four pending bundles; no byte is ever dropped.
//   Reset (arst_n low) empties the queue and returns to the idle phase.
// ----------------------------------------------------------------------------
module percent_escape_decoder_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [ped_pkg::BYTE_W-1:0]  in_byte,
	input  logic                        in_last,
	output logic                        empty,
	input  logic                        pop,
	output logic [ped_pkg::BYTE_W-1:0]  out_byte,
	output logic                        run_end,
	output logic                        stream_end
);

	ped_pkg::bundle_t bnd, head;
	logic             bnd_valid, take, head_pop, q_empty;

	assign take = push && !full;

	// front end: classify and decode
	ped_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.bnd_valid (bnd_valid),
		.bnd       (bnd)
	);

	// bundle queue between the two halves
	ped_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (bnd_valid),
		.wr_data (bnd),
		.rd_en   (head_pop),
		.rd_data (head),
		.full    (full),
		.empty   (q_empty)
	);

	// back end: serialise bytes
	ped_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (q_empty),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.stream_end (stream_end)
	);

	// the string's last byte always yields output
	assert property (@(posedge clk) disable iff (!arst_n)
		take && in_last |-> bnd_valid)
		else $error("last byte produced no output");

	// a queued bundle is never empty
	assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> head.cnt != '0)
		else $error("empty bundle in queue");

	// bytes remain after taking a byte that does not end its run
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !run_end |=> !empty)
		else $error("run cut short");

	// a stream end is always also a run end
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && stream_end |-> run_end)
		else $error("stream end without run end");

endmodule
